// ----- rtl/gtb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gtb_pkg
// Shared types, constants and helpers for the glyph text blitter.
// ----------------------------------------------------------------------------
package gtb_pkg;

    // Default sizes of the glyph sheet.
    localparam int NUM_GLYPHS_DEF     = 65;
    localparam int MAX_GLYPH_SIZE_DEF = 8;

    // First printable code and the pen column limit.
    localparam int CHAR_BASE = 32;
    localparam int PEN_MAX   = 8191;

    // Fixed field widths.
    localparam int FB_W    = 13;
    localparam int PEN_X_W = 13;
    localparam int PEN_Y_W = 12;
    localparam int ADDR_W  = 24;
    localparam int COLOR_W = 32;
    localparam int GSIZE_W = 4;
    localparam int CFG_IDX_W = 3;

    // The serial multiply-add consumes one multiplier bit per cycle.
    localparam int MUL_W = 13;
    localparam int MUL_CNT_W = $clog2(MUL_W + 1);

    // Register reset values.
    localparam logic [FB_W-1:0]    FB_WIDTH_RST     = 13'd224;
    localparam logic [FB_W-1:0]    FB_HEIGHT_RST    = 13'd256;
    localparam logic [GSIZE_W-1:0] GLYPH_WIDTH_RST  = 4'd5;
    localparam logic [GSIZE_W-1:0] GLYPH_HEIGHT_RST = 4'd7;
    localparam logic [COLOR_W-1:0] DRAW_COLOR_RST   = 32'hFFFF_FFFF;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR   = 3'd4;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_PEN  = 2'd1,
        CMD_CHAR = 2'd2
    } t_cmd;

    // Request to the base address multiply-add: mplier * mcand + addend.
    typedef struct packed {
        logic               start;
        logic [FB_W-1:0]    mcand;
        logic [MUL_W-1:0]   mplier;
        logic [PEN_X_W-1:0] addend;
    } t_mac_req;

    typedef struct packed {
        logic              busy;
        logic [ADDR_W-1:0] result;
    } t_mac_rsp;

    // Limits a glyph dimension to 1..maxv.
    function automatic logic [GSIZE_W-1:0] clamp_size(input logic [GSIZE_W-1:0] v,
                                                      input logic [GSIZE_W-1:0] maxv);
        logic [GSIZE_W-1:0] r;
        if (v == '0) begin
            r = GSIZE_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/gtb_addr_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gtb_addr_mac
// Bit-serial multiply-add that forms the top-of-column base address.
// ----------------------------------------------------------------------------
module gtb_addr_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gtb_pkg::t_mac_req i_req,
    output gtb_pkg::t_mac_rsp o_rsp
);

    logic                           r_busy;
    logic [gtb_pkg::MUL_CNT_W-1:0]  r_cnt;
    logic [gtb_pkg::ADDR_W-1:0]     r_acc;
    logic [gtb_pkg::ADDR_W-1:0]     r_mcand;
    logic [gtb_pkg::MUL_W-1:0]      r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + gtb_pkg::MUL_CNT_W'(1);
            if (r_cnt == gtb_pkg::MUL_CNT_W'(gtb_pkg::MUL_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // One multiplier bit per cycle; the sum wraps at the address width.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc    <= gtb_pkg::ADDR_W'(i_req.addend);
            r_mcand  <= gtb_pkg::ADDR_W'(i_req.mcand);
            r_mplier <= i_req.mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.result = r_acc;

endmodule
`default_nettype wire

// ----- rtl/glyph_text_blitter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_text_blitter
// Draws characters from a one-bit glyph sheet into framebuffer pixel writes.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+------------------------------------------
//  input    | i_valid / o_stall      | command, glyph_index, glyph_row, row_bits,
//           |                        | char_code, pos_x, pos_y
//  output   | o_valid / i_stall      | write_valid, pixel_address, pixel_color, last
//  config   | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// Load and pen requests need no setup. A drawn character first runs a setup,
// set by the 13-step serial multiply-add for the column base address (the glyph
// rows are fetched from the sheet memory meanwhile); then the emitter loads one
// result per cycle into the output register while the output is not stalled,
// for glyph_width * glyph_height results (sizes clamped). A stalled output holds
// the emitter; the next request is taken once the last result is in the output
// register. Reset clears the pen and registers but not the glyph sheet.
// ----------------------------------------------------------------------------
module glyph_text_blitter #(
    parameter int NUM_GLYPHS     = gtb_pkg::NUM_GLYPHS_DEF,
    parameter int MAX_GLYPH_SIZE = gtb_pkg::MAX_GLYPH_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [6:0]  i_glyph_index,
    input  logic [2:0]  i_glyph_row,
    input  logic [7:0]  i_row_bits,
    input  logic [7:0]  i_char_code,
    input  logic [11:0] i_pos_x,
    input  logic [11:0] i_pos_y,

    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_write_valid,
    output logic [23:0] o_pixel_address,
    output logic [31:0] o_pixel_color,
    output logic        o_last,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int MEM_DEPTH = NUM_GLYPHS * MAX_GLYPH_SIZE;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int GI_W      = (NUM_GLYPHS > 1) ? $clog2(NUM_GLYPHS) : 1;
    localparam int SZ_W      = $clog2(MAX_GLYPH_SIZE + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_EMIT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [12:0] r_fb_width;
    logic [12:0] r_fb_height;
    logic [3:0]  r_glyph_width;
    logic [3:0]  r_glyph_height;
    logic [31:0] r_draw_color;

    // Pen.
    logic [12:0] r_pen_col;
    logic [11:0] r_pen_row;

    // Glyph sheet and row fetch.
    logic [7:0]        r_mem [MEM_DEPTH];
    logic [7:0]        r_rd_data;
    logic              r_rd_pend;
    logic [SZ_W-1:0]   r_rd_cnt;
    logic [GI_W-1:0]   r_glyph;
    logic [7:0]        r_rows [MAX_GLYPH_SIZE];
    logic [MAX_GLYPH_SIZE-1:0] r_col;

    // Per-character walk.
    logic [SZ_W-1:0]   r_gw;
    logic [SZ_W-1:0]   r_gh;
    logic [SZ_W-1:0]   r_xi;
    logic [SZ_W-1:0]   r_yi;
    logic [12:0]       r_sy_top;
    logic [12:0]       r_sy;
    logic [13:0]       r_sx;
    logic [23:0]       r_col_base;
    logic [23:0]       r_addr;

    // Output register.
    logic        r_out_valid;
    logic        r_out_wv;
    logic [23:0] r_out_addr;
    logic [31:0] r_out_color;
    logic        r_out_last;

    gtb_pkg::t_mac_req w_mac_req;
    gtb_pkg::t_mac_rsp w_mac_rsp;

    logic              w_in_acc;
    logic              w_cfg_we;
    logic [7:0]        w_code_off;
    logic              w_char_ok;
    logic              w_char_go;
    logic              w_load_ok;
    logic              w_mem_we;
    logic [MEM_AW-1:0] w_wr_addr;
    logic [MEM_AW-1:0] w_rd_addr;
    logic              w_rd_issue;
    logic [SZ_W-1:0]   w_gw;
    logic [SZ_W-1:0]   w_gh;
    logic [12:0]       w_sy_top;
    logic              w_setup_done;
    logic              w_out_load;
    logic              w_col_end;
    logic              w_last;
    logic              w_set;
    logic              w_col_step;
    logic [13:0]       w_pen_next;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    assign w_code_off = i_char_code - 8'(gtb_pkg::CHAR_BASE);
    assign w_char_ok  = (i_char_code >= 8'(gtb_pkg::CHAR_BASE))
                     && ({1'b0, w_code_off} < 9'(NUM_GLYPHS));
    assign w_char_go  = w_in_acc && (gtb_pkg::t_cmd'(i_command) == gtb_pkg::CMD_CHAR)
                     && w_char_ok;

    assign w_load_ok = ({2'b00, i_glyph_index} < 9'(NUM_GLYPHS))
                    && ({1'b0, i_glyph_row} < 4'(MAX_GLYPH_SIZE));
    assign w_mem_we  = w_in_acc && (gtb_pkg::t_cmd'(i_command) == gtb_pkg::CMD_LOAD)
                    && w_load_ok;
    assign w_wr_addr = MEM_AW'(int'(i_glyph_index) * MAX_GLYPH_SIZE + int'(i_glyph_row));

    assign w_rd_issue = (r_state == S_SETUP) && (r_rd_cnt != SZ_W'(MAX_GLYPH_SIZE));
    assign w_rd_addr  = MEM_AW'(int'(r_glyph) * MAX_GLYPH_SIZE + int'(r_rd_cnt));

    assign w_gw = SZ_W'(gtb_pkg::clamp_size(r_glyph_width, 4'(MAX_GLYPH_SIZE)));
    assign w_gh = SZ_W'(gtb_pkg::clamp_size(r_glyph_height, 4'(MAX_GLYPH_SIZE)));

    // Glyph row 0 lands on the highest screen row of the character cell.
    assign w_sy_top = {1'b0, r_pen_row} + 13'(w_gh) - 13'd1;

    assign w_mac_req.start  = w_char_go;
    assign w_mac_req.mcand  = r_fb_width;
    assign w_mac_req.mplier = w_sy_top;
    assign w_mac_req.addend = r_pen_col;

    gtb_addr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mac_req),
        .o_rsp   (w_mac_rsp)
    );

    assign w_setup_done = (r_state == S_SETUP) && !w_mac_rsp.busy
                       && !w_rd_issue && !r_rd_pend;

    assign w_out_load = (r_state == S_EMIT) && (!r_out_valid || !i_stall);
    assign w_col_end  = (r_yi == r_gh - SZ_W'(1));
    assign w_last     = w_col_end && (r_xi == r_gw - SZ_W'(1));
    assign w_set      = r_col[0] && (r_sy < r_fb_height) && (r_sx < {1'b0, r_fb_width});
    assign w_col_step = w_setup_done || (w_out_load && w_col_end);

    assign w_pen_next = {1'b0, r_pen_col} + 14'(r_gw) + 14'd1;

    // Control state, configuration and pen.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_fb_width     <= gtb_pkg::FB_WIDTH_RST;
            r_fb_height    <= gtb_pkg::FB_HEIGHT_RST;
            r_glyph_width  <= gtb_pkg::GLYPH_WIDTH_RST;
            r_glyph_height <= gtb_pkg::GLYPH_HEIGHT_RST;
            r_draw_color   <= gtb_pkg::DRAW_COLOR_RST;
            r_pen_col      <= '0;
            r_pen_row      <= '0;
            r_rd_pend      <= 1'b0;
            r_rd_cnt       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_rd_pend <= w_rd_issue;

            if (w_cfg_we) begin
                case (i_cfg_index)
                    gtb_pkg::CFG_FB_WIDTH:     r_fb_width     <= i_cfg_data[12:0];
                    gtb_pkg::CFG_FB_HEIGHT:    r_fb_height    <= i_cfg_data[12:0];
                    gtb_pkg::CFG_GLYPH_WIDTH:  r_glyph_width  <= i_cfg_data[3:0];
                    gtb_pkg::CFG_GLYPH_HEIGHT: r_glyph_height <= i_cfg_data[3:0];
                    gtb_pkg::CFG_DRAW_COLOR:   r_draw_color   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (gtb_pkg::t_cmd'(i_command) == gtb_pkg::CMD_PEN)) begin
                        r_pen_col <= {1'b0, i_pos_x};
                        r_pen_row <= i_pos_y;
                    end
                    if (w_char_go) begin
                        r_rd_cnt <= '0;
                        r_state  <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    if (w_rd_issue) begin
                        r_rd_cnt <= r_rd_cnt + SZ_W'(1);
                    end
                    if (w_setup_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_load && w_last) begin
                        r_state <= S_IDLE;
                        if (w_pen_next > 14'(gtb_pkg::PEN_MAX)) begin
                            r_pen_col <= 13'(gtb_pkg::PEN_MAX);
                        end else begin
                            r_pen_col <= w_pen_next[12:0];
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Glyph sheet memory.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= i_row_bits;
        end
        if (w_rd_issue) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Datapath: row buffer, column shifter, walk counters and output payload.
    always_ff @(posedge i_clk) begin
        if (w_char_go) begin
            r_glyph  <= w_code_off[GI_W-1:0];
            r_gw     <= w_gw;
            r_gh     <= w_gh;
            r_sy_top <= w_sy_top;
        end

        // Fetched rows shift in from the top, so row 0 ends up in the first slot.
        if (r_rd_pend) begin
            for (int i = 0; i < MAX_GLYPH_SIZE - 1; i++) begin
                r_rows[i] <= r_rows[i+1];
            end
            r_rows[MAX_GLYPH_SIZE-1] <= r_rd_data;
        end else if (w_col_step) begin
            for (int i = 0; i < MAX_GLYPH_SIZE; i++) begin
                r_rows[i] <= r_rows[i] >> 1;
            end
        end

        // The column register holds one glyph column, row 0 in bit 0.
        if (w_col_step) begin
            for (int i = 0; i < MAX_GLYPH_SIZE; i++) begin
                r_col[i] <= r_rows[i][0];
            end
        end else if (w_out_load) begin
            r_col <= r_col >> 1;
        end

        if (w_setup_done) begin
            r_xi       <= '0;
            r_yi       <= '0;
            r_sy       <= r_sy_top;
            r_sx       <= {1'b0, r_pen_col};
            r_col_base <= w_mac_rsp.result;
            r_addr     <= w_mac_rsp.result;
        end else if (w_out_load) begin
            if (w_col_end) begin
                r_yi       <= '0;
                r_xi       <= r_xi + SZ_W'(1);
                r_sy       <= r_sy_top;
                r_sx       <= r_sx + 14'd1;
                r_col_base <= r_col_base + 24'd1;
                r_addr     <= r_col_base + 24'd1;
            end else begin
                r_yi   <= r_yi + SZ_W'(1);
                r_sy   <= r_sy - 13'd1;
                r_addr <= r_addr - {11'd0, r_fb_width};
            end
        end

        if (w_out_load) begin
            r_out_wv    <= w_set;
            r_out_addr  <= w_set ? r_addr : '0;
            r_out_color <= w_set ? r_draw_color : '0;
            r_out_last  <= w_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_write_valid   = r_out_wv;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_color   = r_out_color;
    assign o_last          = r_out_last;

endmodule
`default_nettype wire

// ----- bench/glyph_text_blitter_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_text_blitter_test
// Self-checking bench for the glyph text blitter. Glyph rows, pen moves and
// characters are sent with random gaps while the result side stalls at
// random. A scoreboard keeps its own copy of the glyph sheet, pen and
// registers. It predicts every pixel result of a drawn character and
// compares each result as it arrives. The run starts with a directed set of
// requests. Random phases follow under several register settings, ending
// with a long one-row string whose addresses wrap past 24 bits.
// ----------------------------------------------------------------------------
module glyph_text_blitter_test;

    localparam int GLYPH_COUNT    = gtb_pkg::NUM_GLYPHS_DEF;
    localparam int ROWS_PER_GLYPH = gtb_pkg::MAX_GLYPH_SIZE_DEF;
    localparam int SHEET_ROWS     = GLYPH_COUNT * ROWS_PER_GLYPH;
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int GAP_MAX      = 5;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 45;
    localparam int WALK_CHARS   = 85;
    localparam int REPORT_LIMIT = 200;
    localparam logic [7:0] DIRECTED_ROWS [8] = '{8'hFF, 8'h00, 8'hA5, 8'h5A,
                                                 8'h81, 8'h7E, 8'h01, 8'h80};

    typedef struct packed {
        logic                        write_valid;
        logic [gtb_pkg::ADDR_W-1:0]  address;
        logic [gtb_pkg::COLOR_W-1:0] color;
        logic                        last;
    } t_pixel_write;

    class t_blit_scoreboard;
        logic [7:0]                  sheet [SHEET_ROWS];
        bit                          loaded [SHEET_ROWS];
        logic [gtb_pkg::FB_W-1:0]    fb_width;
        logic [gtb_pkg::FB_W-1:0]    fb_height;
        logic [gtb_pkg::GSIZE_W-1:0] glyph_w;
        logic [gtb_pkg::GSIZE_W-1:0] glyph_h;
        logic [gtb_pkg::COLOR_W-1:0] color;
        int unsigned                 pen_x;
        int unsigned                 pen_y;
        t_pixel_write                pending_pixels [$];
        int                          errors;

        function new();
            fb_width  = gtb_pkg::FB_WIDTH_RST;
            fb_height = gtb_pkg::FB_HEIGHT_RST;
            glyph_w   = gtb_pkg::GLYPH_WIDTH_RST;
            glyph_h   = gtb_pkg::GLYPH_HEIGHT_RST;
            color     = gtb_pkg::DRAW_COLOR_RST;
            pen_x     = 0;
            pen_y     = 0;
            errors    = 0;
        endfunction

        function int unsigned clamped(logic [gtb_pkg::GSIZE_W-1:0] v);
            if (v == 0) begin
                return 1;
            end
            if (v > ROWS_PER_GLYPH) begin
                return ROWS_PER_GLYPH;
            end
            return 32'(v);
        endfunction

        function void set_register(logic [gtb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                gtb_pkg::CFG_FB_WIDTH:     fb_width  = data[gtb_pkg::FB_W-1:0];
                gtb_pkg::CFG_FB_HEIGHT:    fb_height = data[gtb_pkg::FB_W-1:0];
                gtb_pkg::CFG_GLYPH_WIDTH:  glyph_w   = data[gtb_pkg::GSIZE_W-1:0];
                gtb_pkg::CFG_GLYPH_HEIGHT: glyph_h   = data[gtb_pkg::GSIZE_W-1:0];
                gtb_pkg::CFG_DRAW_COLOR:   color     = data;
                default: ;
            endcase
        endfunction

        // Notes an accepted request and queues the pixels it will produce.
        function void note_request(logic [1:0] cmd, logic [6:0] gidx, logic [2:0] grow,
                                   logic [7:0] bits, logic [7:0] code,
                                   logic [11:0] px, logic [11:0] py);
            int unsigned gw, gh, sx, sy, glyph, total, n, c;
            logic [7:0] rowv;
            t_pixel_write pix;
            c = 32'(code);
            case (cmd)
                gtb_pkg::CMD_LOAD: begin
                    if (gidx < GLYPH_COUNT) begin
                        sheet[gidx * ROWS_PER_GLYPH + grow] = bits;
                        loaded[gidx * ROWS_PER_GLYPH + grow] = 1'b1;
                    end
                end
                gtb_pkg::CMD_PEN: begin
                    pen_x = 32'(px);
                    pen_y = 32'(py);
                end
                gtb_pkg::CMD_CHAR: begin
                    if (c >= gtb_pkg::CHAR_BASE && c - gtb_pkg::CHAR_BASE < GLYPH_COUNT) begin
                        glyph = c - gtb_pkg::CHAR_BASE;
                        gw = clamped(glyph_w);
                        gh = clamped(glyph_h);
                        total = gw * gh;
                        n = 0;
                        // Column by column; row 0 of the glyph is the top screen row.
                        for (int xi = 0; xi < gw; xi++) begin
                            for (int yi = 0; yi < gh; yi++) begin
                                rowv = sheet[glyph * ROWS_PER_GLYPH + yi];
                                sy = pen_y + gh - 1 - yi;
                                sx = pen_x + xi;
                                n++;
                                pix = '0;
                                if (rowv[xi] && sy < fb_height && sx < fb_width) begin
                                    pix.write_valid = 1'b1;
                                    pix.address = gtb_pkg::ADDR_W'(sy * fb_width + sx);
                                    pix.color = color;
                                end
                                pix.last = (n == total);
                                pending_pixels.push_back(pix);
                            end
                        end
                        if (pen_x + gw + 1 > gtb_pkg::PEN_MAX) begin
                            pen_x = gtb_pkg::PEN_MAX;
                        end else begin
                            pen_x = pen_x + gw + 1;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: %s expected %h, got %h", $time, field, want, got);
                end
            end
        endfunction

        function void check_result(t_pixel_write got);
            t_pixel_write want;
            if (pending_pixels.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: unexpected pixel result, expected none, got %h",
                             $time, got);
                end
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
            compare_field("pixel_address", 32'(want.address), 32'(got.address));
            compare_field("pixel_color", want.color, got.color);
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_command;
    logic [6:0]  i_glyph_index;
    logic [2:0]  i_glyph_row;
    logic [7:0]  i_row_bits;
    logic [7:0]  i_char_code;
    logic [11:0] i_pos_x;
    logic [11:0] i_pos_y;
    logic        o_valid;
    logic        i_stall;
    logic        o_write_valid;
    logic [23:0] o_pixel_address;
    logic [31:0] o_pixel_color;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    t_blit_scoreboard sb = new();
    bit               eager;
    int unsigned      stall_left;
    int unsigned      idle_cycles;

    glyph_text_blitter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_glyph_index   (i_glyph_index),
        .i_glyph_row     (i_glyph_row),
        .i_row_bits      (i_row_bits),
        .i_char_code     (i_char_code),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_write_valid   (o_write_valid),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Result side: check on acceptance, then draw the stall before the next one.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            sb.check_result({o_write_valid, o_pixel_address, o_pixel_color, o_last});
            stall_left = eager ? 0 : $urandom_range(0, GAP_MAX);
        end
    end

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Every request task is entered and left at a falling edge.
    task automatic send_request(input logic [1:0] cmd, input logic [6:0] gidx,
                                input logic [2:0] grow, input logic [7:0] bits,
                                input logic [7:0] code, input logic [11:0] px,
                                input logic [11:0] py);
        int unsigned gap;
        gap = eager ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_glyph_index <= gidx;
        i_glyph_row   <= grow;
        i_row_bits    <= bits;
        i_char_code   <= code;
        i_pos_x       <= px;
        i_pos_y       <= py;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        sb.note_request(cmd, gidx, grow, bits, code, px, py);
        @(negedge i_clk);
    endtask

    task automatic load_row(input logic [6:0] gidx, input logic [2:0] grow,
                            input logic [7:0] bits);
        send_request(gtb_pkg::CMD_LOAD, gidx, grow, bits, 8'($urandom), 12'($urandom),
                     12'($urandom));
    endtask

    task automatic set_pen(input logic [11:0] px, input logic [11:0] py);
        send_request(gtb_pkg::CMD_PEN, 7'($urandom), 3'($urandom), 8'($urandom),
                     8'($urandom), px, py);
    endtask

    task automatic draw_char(input logic [7:0] code);
        send_request(gtb_pkg::CMD_CHAR, 7'($urandom), 3'($urandom), 8'($urandom), code,
                     12'($urandom), 12'($urandom));
    endtask

    task automatic write_register(input logic [gtb_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        sb.set_register(idx, data);
        @(negedge i_clk);
    endtask

    // Bits above each register's width carry random junk that must be ignored.
    task automatic configure(input logic [gtb_pkg::FB_W-1:0] fbw,
                             input logic [gtb_pkg::FB_W-1:0] fbh,
                             input logic [gtb_pkg::GSIZE_W-1:0] gw,
                             input logic [gtb_pkg::GSIZE_W-1:0] gh,
                             input logic [gtb_pkg::COLOR_W-1:0] color);
        write_register(gtb_pkg::CFG_FB_WIDTH, ($urandom << gtb_pkg::FB_W) | fbw);
        write_register(gtb_pkg::CFG_FB_HEIGHT, ($urandom << gtb_pkg::FB_W) | fbh);
        write_register(gtb_pkg::CFG_GLYPH_WIDTH, ($urandom << gtb_pkg::GSIZE_W) | gw);
        write_register(gtb_pkg::CFG_GLYPH_HEIGHT, ($urandom << gtb_pkg::GSIZE_W) | gh);
        write_register(gtb_pkg::CFG_DRAW_COLOR, color);
        i_cfg_valid <= 1'b0;
    endtask

    // Skipped characters give no result, so allow extra time after the last pixel.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Only glyphs whose visible rows are all loaded may be drawn.
    function automatic int pick_ready_glyph();
        int ready [$];
        int unsigned gh;
        bit ok;
        gh = sb.clamped(sb.glyph_h);
        for (int g = 0; g < GLYPH_COUNT; g++) begin
            ok = 1'b1;
            for (int r = 0; r < gh; r++) begin
                if (!sb.loaded[g * ROWS_PER_GLYPH + r]) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                ready.push_back(g);
            end
        end
        if (ready.size() == 0) begin
            return -1;
        end
        return ready[$urandom_range(0, ready.size() - 1)];
    endfunction

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_request(CMD_NONE, 7'($urandom), 3'($urandom), 8'($urandom),
                            8'($urandom), 12'($urandom), 12'($urandom));
            1: begin
                if ($urandom_range(0, 1) == 0) begin
                    draw_char(8'($urandom_range(0, gtb_pkg::CHAR_BASE - 1)));
                end else begin
                    draw_char(8'($urandom_range(gtb_pkg::CHAR_BASE + GLYPH_COUNT, 255)));
                end
            end
            2: load_row(7'($urandom_range(GLYPH_COUNT, 127)), 3'($urandom), 8'($urandom));
            default: load_row(7'($urandom_range(0, GLYPH_COUNT - 1)), 3'($urandom),
                              8'($urandom));
        endcase
    endtask

    task automatic run_phase(input logic [gtb_pkg::FB_W-1:0] fbw,
                             input logic [gtb_pkg::FB_W-1:0] fbh,
                             input logic [gtb_pkg::GSIZE_W-1:0] gw,
                             input logic [gtb_pkg::GSIZE_W-1:0] gh,
                             input logic [gtb_pkg::COLOR_W-1:0] color);
        int sent, pick, g, len, reach_x, reach_y;
        configure(fbw, fbh, gw, gh, color);
        reach_x = (fbw > 4095) ? 4095 : int'(fbw);
        reach_y = (fbh > 4095) ? 4095 : int'(fbh);
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            eager = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                g = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) * (GLYPH_COUNT - 1))
                                                : $urandom_range(0, GLYPH_COUNT - 1);
                for (int r = 0; r < ROWS_PER_GLYPH; r++) begin
                    load_row(7'(g), 3'(r), 8'($urandom));
                end
                sent += ROWS_PER_GLYPH;
            end else if (pick < 25) begin
                if ($urandom_range(0, 3) == 0) begin
                    set_pen(12'($urandom), 12'($urandom));
                end else begin
                    set_pen(12'($urandom_range(0, reach_x)), 12'($urandom_range(0, reach_y)));
                end
                sent++;
            end else if (pick < 85) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    g = pick_ready_glyph();
                    if (g >= 0) begin
                        draw_char(8'(gtb_pkg::CHAR_BASE + g));
                    end
                end
                sent += len;
            end else begin
                send_noise();
            end
        end
        drain();
    endtask

    initial begin
        int g;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_command     = gtb_pkg::CMD_LOAD;
        i_glyph_index = '0;
        i_glyph_row   = '0;
        i_row_bits    = '0;
        i_char_code   = '0;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_stall       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = gtb_pkg::CFG_FB_WIDTH;
        i_cfg_data    = '0;
        eager         = 1'b0;
        stall_left    = 0;
        idle_cycles   = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The highest glyph, drawn first from the pen position left by reset.
        for (int r = 0; r < ROWS_PER_GLYPH; r++) begin
            load_row(7'(GLYPH_COUNT - 1), 3'(r), DIRECTED_ROWS[r]);
        end
        draw_char(8'(gtb_pkg::CHAR_BASE + GLYPH_COUNT - 1));
        load_row(7'h7F, 3'h7, 8'hFF);
        send_request(CMD_NONE, 7'h7F, 3'h7, 8'hFF, 8'(gtb_pkg::CHAR_BASE + GLYPH_COUNT - 1),
                     12'hFFF, 12'hFFF);
        draw_char(8'h00);
        draw_char(8'(gtb_pkg::CHAR_BASE - 1));
        draw_char(8'(gtb_pkg::CHAR_BASE + GLYPH_COUNT));
        draw_char(8'hFF);
        set_pen(12'hFFF, 12'hFFF);
        draw_char(8'(gtb_pkg::CHAR_BASE + GLYPH_COUNT - 1));
        set_pen(12'd0, 12'd0);
        draw_char(8'(gtb_pkg::CHAR_BASE + GLYPH_COUNT - 1));
        set_pen(12'd220, 12'd250);
        draw_char(8'(gtb_pkg::CHAR_BASE + GLYPH_COUNT - 1));
        draw_char(8'(gtb_pkg::CHAR_BASE + GLYPH_COUNT - 1));
        drain();

        run_phase(gtb_pkg::FB_WIDTH_RST, gtb_pkg::FB_HEIGHT_RST, gtb_pkg::GLYPH_WIDTH_RST,
                  gtb_pkg::GLYPH_HEIGHT_RST, $urandom);
        run_phase(13'd1, 13'd1, 4'd1, 4'd1, 32'h0000_0000);
        run_phase(13'd4096, 13'd4096, 4'd8, 4'd8, $urandom);
        run_phase(13'd0, 13'd100, 4'd0, 4'd15, $urandom);
        run_phase(13'd100, 13'd0, 4'd15, 4'd0, $urandom);
        run_phase(13'd8191, 13'd8191, 4'd3, 4'd4, $urandom);
        run_phase(13'($urandom_range(1, 300)), 13'($urandom_range(1, 300)),
                  4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)), $urandom);

        // A long one-row string near the far corner: addresses wrap past 24 bits.
        configure(13'd8191, 13'd8191, 4'd8, 4'd1, $urandom);
        set_pen(12'(4095 - $urandom_range(0, 50)), 12'hFFF);
        for (int n = 0; n < WALK_CHARS; n++) begin
            if (n % 20 == 0) begin
                eager = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 9) == 0) begin
                send_noise();
            end
            g = pick_ready_glyph();
            if (g >= 0) begin
                draw_char(8'(gtb_pkg::CHAR_BASE + g));
            end
        end
        drain();

        if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
